### hw/rtl/lr4_pkg.sv
// ----------------------------------------------------------------------------
// lr4_pkg
// shared types and constants of the lr4 crossover band splitter
// ----------------------------------------------------------------------------
`default_nettype none

package lr4_pkg;

	// coefficient format q2.30
	localparam int COEF_BITS  = 32;
	// guard bits of the section state below the sample lsb
	localparam int GUARD_BITS = 8;
	// coefficient product brought to state units
	localparam int PROD_SHIFT = COEF_BITS - 2 - GUARD_BITS;

	// apb register map
	localparam int ADDR_BITS  = 4;
	localparam int DATA_BITS  = 32;

	typedef enum logic [1:0] {
		REG_LOW_PASS_GAIN,
		REG_HIGH_PASS_GAIN,
		REG_FEEDBACK_FIRST,
		REG_FEEDBACK_SECOND
	} reg_idx_t;

	// sections per channel: low pass pair, then high pass pair
	typedef logic [1:0] sec_t;
	localparam sec_t FIRST_SECTION   = 2'd0;
	localparam sec_t LOW_OUT_SECTION = 2'd1;
	localparam sec_t LAST_SECTION    = 2'd3;

	typedef struct packed {
		logic signed [COEF_BITS-1:0] low_pass_gain;
		logic signed [COEF_BITS-1:0] high_pass_gain;
		logic signed [COEF_BITS-1:0] feedback_first;
		logic signed [COEF_BITS-1:0] feedback_second;
	} coef_t;

	typedef enum logic [1:0] {
		MUL_B0,
		MUL_A1,
		MUL_A2
	} mul_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_FORM,
		ST_MUL_A1,
		ST_MUL_A2,
		ST_WRITE,
		ST_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic     ld_in;
		logic     rd_en;
		sec_t     sec;
		mul_sel_t mul_sel;
		logic     form_en;
		logic     n1_en;
		logic     wr_en;
		sec_t     wr_sec;
		logic     out_ld;
		logic     out_zero;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic ch_ok;
	} status_t;

endpackage

`default_nettype wire

### hw/rtl/lr4_if.sv
// ----------------------------------------------------------------------------
// lr4 stream interfaces
// valid/ready channels for sample items and band result items
// ----------------------------------------------------------------------------
`default_nettype none

interface lr4_in_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic                          channel;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output channel, output sample, input ready);
	modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface lr4_out_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic                          out_channel;
	logic signed [SAMPLE_BITS-1:0] low_sample;
	logic signed [SAMPLE_BITS-1:0] high_sample;

	modport source (output valid, output out_channel, output low_sample,
		output high_sample, input ready);
	modport sink   (input valid, input out_channel, input low_sample,
		input high_sample, output ready);
endinterface

`default_nettype wire

### hw/rtl/lr4_ctrl.sv
// ----------------------------------------------------------------------------
// lr4_ctrl
// sequencer: walks the four biquad sections of one item and owns the handshakes
// ----------------------------------------------------------------------------
`default_nettype none

module lr4_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire lr4_pkg::status_t status,
	output lr4_pkg::cmd_t         cmd
);

	lr4_pkg::state_t state_q, state_d;
	lr4_pkg::sec_t   sec_q, sec_d;
	logic            zero_q, zero_d;
	logic            out_vld_q;
	logic            slot_free;

	assign slot_free = !out_vld_q || out_ready;
	assign out_valid = out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lr4_pkg::ST_IDLE;
			sec_q     <= lr4_pkg::FIRST_SECTION;
			zero_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sec_q   <= sec_d;
			zero_q  <= zero_d;
			if (cmd.out_ld) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		sec_d        = sec_q;
		zero_d       = zero_q;
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.sec      = sec_q;
		cmd.wr_sec   = sec_q;
		cmd.mul_sel  = lr4_pkg::MUL_B0;
		unique case (state_q)
			lr4_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.ld_in = 1'b1;
					sec_d     = lr4_pkg::FIRST_SECTION;
					zero_d    = !status.ch_ok;
					state_d   = status.ch_ok ? lr4_pkg::ST_START : lr4_pkg::ST_FINISH;
				end
			end
			lr4_pkg::ST_START: begin
				cmd.rd_en = 1'b1;
				state_d   = lr4_pkg::ST_FORM;
			end
			lr4_pkg::ST_FORM: begin
				cmd.form_en = 1'b1;
				state_d     = lr4_pkg::ST_MUL_A1;
			end
			lr4_pkg::ST_MUL_A1: begin
				cmd.mul_sel = lr4_pkg::MUL_A1;
				state_d     = lr4_pkg::ST_MUL_A2;
			end
			lr4_pkg::ST_MUL_A2: begin
				cmd.mul_sel = lr4_pkg::MUL_A2;
				cmd.n1_en   = 1'b1;
				state_d     = lr4_pkg::ST_WRITE;
			end
			lr4_pkg::ST_WRITE: begin
				cmd.wr_en = 1'b1;
				if (sec_q != lr4_pkg::LAST_SECTION) begin
					// next section starts while this one is written back
					cmd.rd_en = 1'b1;
					cmd.sec   = sec_q + 2'd1;
					sec_d     = sec_q + 2'd1;
					state_d   = lr4_pkg::ST_FORM;
				end else if (slot_free) begin
					cmd.out_ld = 1'b1;
					state_d    = lr4_pkg::ST_IDLE;
				end else begin
					state_d = lr4_pkg::ST_FINISH;
				end
			end
			lr4_pkg::ST_FINISH: begin
				if (slot_free) begin
					cmd.out_ld   = 1'b1;
					cmd.out_zero = zero_q;
					state_d      = lr4_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lr4_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### hw/rtl/lr4_dp.sv
// ----------------------------------------------------------------------------
// lr4_dp
// datapath: shared multiplier, section arithmetic, state memory, result register
// ----------------------------------------------------------------------------
`default_nettype none

module lr4_dp #(
	parameter int CHANNELS    = 2,
	parameter int SAMPLE_BITS = 24
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lr4_pkg::cmd_t                 cmd,
	output lr4_pkg::status_t                   status,
	input  wire lr4_pkg::coef_t                coef,
	input  wire logic                          in_channel,
	input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
	output logic                               out_channel,
	output logic signed [SAMPLE_BITS-1:0]      low_sample,
	output logic signed [SAMPLE_BITS-1:0]      high_sample
);

	localparam int SB    = SAMPLE_BITS;
	localparam int ST    = SB + 16;                              // state word
	localparam int PRW   = lr4_pkg::COEF_BITS + SB;              // product
	localparam int PW    = PRW - lr4_pkg::PROD_SHIFT;            // scaled product
	localparam int AW    = ST + 1;                               // accumulator
	localparam int YW    = AW + 1 - lr4_pkg::GUARD_BITS;         // rounded output
	localparam int NW    = ST + 2;                               // state update
	localparam int ROWS  = CHANNELS * 4;
	localparam int ROW_W = $clog2(ROWS);

	function automatic logic signed [SB-1:0] sat_y(input logic signed [YW-1:0] v);
		if (v[YW-1:SB-1] == {(YW-SB+1){v[YW-1]}}) begin
			return v[SB-1:0];
		end
		return {v[YW-1], {(SB-1){~v[YW-1]}}};
	endfunction

	function automatic logic signed [ST-1:0] sat_s(input logic signed [NW-1:0] v);
		if (v[NW-1:ST-1] == {(NW-ST+1){v[NW-1]}}) begin
			return v[ST-1:0];
		end
		return {v[NW-1], {(ST-1){~v[NW-1]}}};
	endfunction

	logic                                  ch_q;
	logic signed [SB-1:0]                  x_q;
	logic signed [SB-1:0]                  y_q;
	logic signed [SB-1:0]                  low_q;
	logic signed [PRW-1:0]                 prod_q;
	logic signed [PW-1:0]                  p_q;
	logic signed [ST-1:0]                  n1_q;
	logic        [2*ST-1:0]                state_mem [ROWS];
	logic        [2*ST-1:0]                rd_row_q;
	logic                                  rd_vld_q;
	logic        [ROWS-1:0]                vld_q;
	logic        [ROW_W-1:0]               rd_addr;
	logic        [ROW_W-1:0]               wr_addr;
	logic signed [lr4_pkg::COEF_BITS-1:0]  mul_a;
	logic signed [SB-1:0]                  mul_b;
	logic signed [PW-1:0]                  prod_sc;
	logic signed [ST-1:0]                  s1;
	logic signed [ST-1:0]                  s2;
	logic signed [AW:0]                    acc_rnd;
	logic signed [NW-1:0]                  kp;
	logic signed [NW-1:0]                  n1_sum;
	logic signed [NW-1:0]                  n2_sum;
	logic signed [SB-1:0]                  out_low_q;
	logic signed [SB-1:0]                  out_high_q;

	// channel 1 exists only when two or more channels are configured
	assign status.ch_ok = !in_channel || (CHANNELS > 1);

	assign rd_addr = ROW_W'({ch_q, cmd.sec});
	assign wr_addr = ROW_W'({ch_q, cmd.wr_sec});

	// shared multiplier operands
	always_comb begin
		mul_a = cmd.sec[1] ? coef.high_pass_gain : coef.low_pass_gain;
		mul_b = cmd.sec[0] ? y_q : x_q;
		case (cmd.mul_sel)
			lr4_pkg::MUL_A1: begin
				mul_a = coef.feedback_first;
				mul_b = y_q;
			end
			lr4_pkg::MUL_A2: begin
				mul_a = coef.feedback_second;
				mul_b = y_q;
			end
			default: begin
			end
		endcase
	end

	assign prod_sc = prod_q[PRW-1:lr4_pkg::PROD_SHIFT];
	assign s1      = rd_vld_q ? rd_row_q[2*ST-1:ST] : '0;
	assign s2      = rd_vld_q ? rd_row_q[ST-1:0]    : '0;

	// round half up on the guard bits
	assign acc_rnd = (AW+1)'(prod_sc) + (AW+1)'(s1)
		+ (AW+1)'(1 << (lr4_pkg::GUARD_BITS - 1));

	// low pass sections feed +2p, high pass sections -2p
	assign kp     = cmd.sec[1] ? -(NW'(p_q) <<< 1) : (NW'(p_q) <<< 1);
	assign n1_sum = kp + NW'(s2) - NW'(prod_sc);
	assign n2_sum = NW'(p_q) - NW'(prod_sc);

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (cmd.ld_in) begin
			ch_q <= in_channel;
			x_q  <= in_sample;
		end
		if (cmd.form_en) begin
			p_q <= prod_sc;
			y_q <= sat_y(acc_rnd[AW:lr4_pkg::GUARD_BITS]);
		end
		if (cmd.n1_en) begin
			n1_q <= sat_s(n1_sum);
		end
		if (cmd.wr_en && cmd.wr_sec == lr4_pkg::LOW_OUT_SECTION) begin
			low_q <= y_q;
		end
		if (cmd.wr_en) begin
			state_mem[wr_addr] <= {n1_q, sat_s(n2_sum)};
		end
		if (cmd.rd_en) begin
			rd_row_q <= state_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (cmd.rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			out_channel <= ch_q;
			out_low_q   <= cmd.out_zero ? '0 : low_q;
			out_high_q  <= cmd.out_zero ? '0 : y_q;
		end
	end

	assign low_sample  = out_low_q;
	assign high_sample = out_high_q;

endmodule

`default_nettype wire

### hw/rtl/lr4_crossover_band_split.sv
// an accepted item runs its 4 biquad sections in turn on the one shared
// multiplier and waits for a free output slot; an unconfigured channel skips
// the sections and yields zero bands; items are taken one at a time, and a new
// item is taken while the previous result still waits at the output
// reset (arst_n, async, low): coefficients zero, all section state reads as zero
// ----------------------------------------------------------------------------
// lr4_crossover_band_split
// linkwitz-riley 4th order crossover splitting samples into low and high bands
// ----------------------------------------------------------------------------
`default_nettype none

module lr4_crossover_band_split #(
	parameter int CHANNELS    = 2,
	parameter int SAMPLE_BITS = 24
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// apb configuration port
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [lr4_pkg::ADDR_BITS-1:0]   paddr,
	input  wire logic [lr4_pkg::DATA_BITS-1:0]   pwdata,
	output logic      [lr4_pkg::DATA_BITS-1:0]   prdata,
	output logic                                 pready,
	// sample items in, band items out
	lr4_in_if.sink                               in_stream,
	lr4_out_if.source                            out_stream
);

	lr4_pkg::coef_t    coef_q;
	lr4_pkg::cmd_t     cmd;
	lr4_pkg::status_t  status;
	lr4_pkg::reg_idx_t reg_idx;
	logic              wr_en;

	// registers sit on word addresses, index in paddr[3:2]
	assign reg_idx = lr4_pkg::reg_idx_t'(paddr[3:2]);
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				lr4_pkg::REG_LOW_PASS_GAIN:   coef_q.low_pass_gain   <= pwdata;
				lr4_pkg::REG_HIGH_PASS_GAIN:  coef_q.high_pass_gain  <= pwdata;
				lr4_pkg::REG_FEEDBACK_FIRST:  coef_q.feedback_first  <= pwdata;
				lr4_pkg::REG_FEEDBACK_SECOND: coef_q.feedback_second <= pwdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			lr4_pkg::REG_LOW_PASS_GAIN:   prdata = coef_q.low_pass_gain;
			lr4_pkg::REG_HIGH_PASS_GAIN:  prdata = coef_q.high_pass_gain;
			lr4_pkg::REG_FEEDBACK_FIRST:  prdata = coef_q.feedback_first;
			lr4_pkg::REG_FEEDBACK_SECOND: prdata = coef_q.feedback_second;
			default:                      prdata = '0;
		endcase
	end

	// sequencer: one section at a time, each as b0 product, output rounding,
	// a1 product, a2 product and state write-back; the next section's b0
	// product and state read overlap the write-back
	lr4_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_stream.valid),
		.in_ready  (in_stream.ready),
		.out_valid (out_stream.valid),
		.out_ready (out_stream.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// arithmetic, per-channel section state and the result register
	lr4_dp #(
		.CHANNELS    (CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.coef        (coef_q),
		.in_channel  (in_stream.channel),
		.in_sample   (in_stream.sample),
		.out_channel (out_stream.out_channel),
		.low_sample  (out_stream.low_sample),
		.high_sample (out_stream.high_sample)
	);

endmodule

`default_nettype wire

### verif/lr4_band_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr4_band_checker
// watches the config port and both streams, predicts every band item from its
// own copy of the coefficients and section state, compares field by field
// ----------------------------------------------------------------------------

module lr4_band_checker #(
	parameter int CHANNELS    = 2,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lr4_pkg::ADDR_BITS-1:0] paddr,
	input  logic [lr4_pkg::DATA_BITS-1:0] pwdata,
	input  logic [lr4_pkg::DATA_BITS-1:0] prdata,
	input  logic                          pready,
	lr4_in_if                             in_mon,
	lr4_out_if                            out_mon,
	output int                            errors,
	output int                            pending,
	output int                            checked
);

	localparam int STATE_BITS = SAMPLE_BITS + 16;

	typedef enum int {
		LOW_FIRST,
		LOW_SECOND,
		HIGH_FIRST,
		HIGH_SECOND
	} section_t;

	typedef struct packed {
		logic                          ch;
		logic signed [SAMPLE_BITS-1:0] low;
		logic signed [SAMPLE_BITS-1:0] high;
	} band_item_t;

	logic signed [lr4_pkg::COEF_BITS-1:0] coef [4];
	longint                               band_state [CHANNELS][4][2];
	band_item_t                           expected_bands [$];
	int                                   err_n;
	int                                   checked_n;

	function automatic longint clamp_to(input longint v, input int bits);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			return hi;
		end
		if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

	// one transposed direct form ii section, state in guard-bit units
	function automatic longint run_section(input int ch, input int sec, input longint b0,
		input longint k, input longint x);
		longint a1;
		longint a2;
		longint p;
		longint acc;
		longint y;
		longint s1n;
		longint s2n;
		a1  = coef[lr4_pkg::REG_FEEDBACK_FIRST];
		a2  = coef[lr4_pkg::REG_FEEDBACK_SECOND];
		p   = (b0 * x) >>> lr4_pkg::PROD_SHIFT;
		acc = p + band_state[ch][sec][0];
		y   = clamp_to((acc + (longint'(1) <<< (lr4_pkg::GUARD_BITS - 1)))
			>>> lr4_pkg::GUARD_BITS, SAMPLE_BITS);
		s1n = k * p + band_state[ch][sec][1] - ((a1 * y) >>> lr4_pkg::PROD_SHIFT);
		s2n = p - ((a2 * y) >>> lr4_pkg::PROD_SHIFT);
		band_state[ch][sec][0] = clamp_to(s1n, STATE_BITS);
		band_state[ch][sec][1] = clamp_to(s2n, STATE_BITS);
		return y;
	endfunction

	function automatic band_item_t predict_bands(input logic ch,
		input logic signed [SAMPLE_BITS-1:0] x);
		band_item_t r;
		longint     lo;
		longint     hi;
		longint     xs;
		lo = 0;
		hi = 0;
		xs = x;
		if (int'(ch) < CHANNELS) begin
			lo = run_section(ch, LOW_FIRST, coef[lr4_pkg::REG_LOW_PASS_GAIN], 2, xs);
			lo = run_section(ch, LOW_SECOND, coef[lr4_pkg::REG_LOW_PASS_GAIN], 2, lo);
			hi = run_section(ch, HIGH_FIRST, coef[lr4_pkg::REG_HIGH_PASS_GAIN], -2, xs);
			hi = run_section(ch, HIGH_SECOND, coef[lr4_pkg::REG_HIGH_PASS_GAIN], -2, hi);
		end
		r.ch   = ch;
		r.low  = lo[SAMPLE_BITS-1:0];
		r.high = hi[SAMPLE_BITS-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		band_item_t         want;
		lr4_pkg::reg_idx_t  idx;
		if (!arst_n) begin
			foreach (coef[i]) begin
				coef[i] = '0;
			end
			foreach (band_state[c, s, w]) begin
				band_state[c][s][w] = 0;
			end
			expected_bands.delete();
			err_n     = 0;
			checked_n = 0;
		end else begin
			// results first: an item accepted at this edge cannot be the one leaving
			if (out_mon.valid && out_mon.ready) begin
				if (expected_bands.size() == 0) begin
					$display("%0t: band item with none expected: ch %0d low %0d high %0d",
						$time, out_mon.out_channel, out_mon.low_sample, out_mon.high_sample);
					err_n++;
				end else begin
					want = expected_bands.pop_front();
					checked_n++;
					if (out_mon.out_channel !== want.ch) begin
						$display("%0t: out_channel expected %0d got %0d",
							$time, want.ch, out_mon.out_channel);
						err_n++;
					end
					if (out_mon.low_sample !== want.low) begin
						$display("%0t: low_sample (ch %0d) expected %0d got %0d",
							$time, want.ch, want.low, out_mon.low_sample);
						err_n++;
					end
					if (out_mon.high_sample !== want.high) begin
						$display("%0t: high_sample (ch %0d) expected %0d got %0d",
							$time, want.ch, want.high, out_mon.high_sample);
						err_n++;
					end
				end
			end
			if (in_mon.valid && in_mon.ready) begin
				expected_bands.push_back(predict_bands(in_mon.channel, in_mon.sample));
			end
			if (psel && penable && pready) begin
				idx = lr4_pkg::reg_idx_t'(paddr[lr4_pkg::ADDR_BITS-1:2]);
				if (pwrite) begin
					coef[idx] = pwdata;
				end else if (prdata !== coef[idx]) begin
					$display("%0t: register %s read expected %h got %h",
						$time, idx.name(), coef[idx], prdata);
					err_n++;
				end
			end
		end
		errors  <= err_n;
		pending <= expected_bands.size();
		checked <= checked_n;
	end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives the crossover with directed and random stereo samples under several
// coefficient sets, with random idle on both sides, and reports the verdict
// ----------------------------------------------------------------------------

module tb_top;

	localparam int CHANNELS    = 2;
	localparam int SAMPLE_BITS = 24;
	// cycles with nothing accepted before the run is declared stuck
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam real FS         = 48000.0;
	localparam real TWO_PI     = 6.283185307179586;

	localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [lr4_pkg::ADDR_BITS-1:0] paddr;
	logic [lr4_pkg::DATA_BITS-1:0] pwdata;
	logic [lr4_pkg::DATA_BITS-1:0] prdata;
	logic                          pready;

	int band_errors;
	int bands_pending;
	int bands_checked;
	int samples_sent;
	int settings_used;
	int stall_cycles = 0;

	// sender idles at random unless this is cleared
	bit  sender_gaps;
	// per channel test tone, gives filter-friendly audio streams
	real tone_phase [CHANNELS];
	real tone_step;
	real tone_amp;
	logic last_ch;

	lr4_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) sample_if ();
	lr4_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) band_if ();

	always #2 clk = ~clk;

	lr4_crossover_band_split #(
		.CHANNELS   (CHANNELS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_stream (sample_if),
		.out_stream(band_if)
	);

	lr4_band_checker #(
		.CHANNELS   (CHANNELS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) chk (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.in_mon (sample_if),
		.out_mon(band_if),
		.errors (band_errors),
		.pending(bands_pending),
		.checked(bands_checked)
	);

	// ------------------------------------------------------------------
	// coefficient helpers
	// ------------------------------------------------------------------

	function automatic logic signed [lr4_pkg::COEF_BITS-1:0] to_q30(input real v);
		return $rtoi(v * 1073741824.0 + ((v < 0.0) ? -0.5 : 0.5));
	endfunction

	// butterworth pair (q = 0.707) at the given crossover frequency
	function automatic lr4_pkg::coef_t butterworth(input real fc);
		lr4_pkg::coef_t c;
		real            w0;
		real            cs;
		real            alpha;
		real            a0;
		w0    = TWO_PI * fc / FS;
		cs    = $cos(w0);
		alpha = $sin(w0) / (2.0 * 0.707);
		a0    = 1.0 + alpha;
		c.low_pass_gain   = to_q30((1.0 - cs) / 2.0 / a0);
		c.high_pass_gain  = to_q30((1.0 + cs) / 2.0 / a0);
		c.feedback_first  = to_q30(-2.0 * cs / a0);
		c.feedback_second = to_q30((1.0 - alpha) / a0);
		return c;
	endfunction

	// ------------------------------------------------------------------
	// apb and stream drivers, all at the rising edge
	// ------------------------------------------------------------------

	task automatic apb_access(input lr4_pkg::reg_idx_t idx, input logic wr,
		input logic [lr4_pkg::DATA_BITS-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		// idle cycle keeps psel from being lowered and raised in one step
		@(posedge clk);
	endtask

	// let every expected band item come out; the block then sits idle
	task automatic drain();
		sample_if.valid <= 1'b0;
		do @(posedge clk); while (bands_pending != 0);
	endtask

	// write all four registers while idle, then read them back
	task automatic configure(input lr4_pkg::coef_t c);
		drain();
		apb_access(lr4_pkg::REG_LOW_PASS_GAIN, 1'b1, c.low_pass_gain);
		apb_access(lr4_pkg::REG_HIGH_PASS_GAIN, 1'b1, c.high_pass_gain);
		apb_access(lr4_pkg::REG_FEEDBACK_FIRST, 1'b1, c.feedback_first);
		apb_access(lr4_pkg::REG_FEEDBACK_SECOND, 1'b1, c.feedback_second);
		apb_access(lr4_pkg::REG_LOW_PASS_GAIN, 1'b0, '0);
		apb_access(lr4_pkg::REG_HIGH_PASS_GAIN, 1'b0, '0);
		apb_access(lr4_pkg::REG_FEEDBACK_FIRST, 1'b0, '0);
		apb_access(lr4_pkg::REG_FEEDBACK_SECOND, 1'b0, '0);
		settings_used++;
	endtask

	// valid stays high from one item to the next unless a gap is drawn
	task automatic send_sample(input logic ch, input logic signed [SAMPLE_BITS-1:0] s);
		if (sender_gaps) begin
			while ($urandom_range(99) < 15) begin
				sample_if.valid <= 1'b0;
				@(posedge clk);
			end
		end
		sample_if.valid   <= 1'b1;
		sample_if.channel <= ch;
		sample_if.sample  <= s;
		do @(posedge clk); while (!sample_if.ready);
		samples_sent++;
		last_ch = ch;
	endtask

	// ------------------------------------------------------------------
	// random content
	// ------------------------------------------------------------------

	task automatic new_tone();
		tone_step = TWO_PI * real'($urandom_range(4000, 20)) / FS;
		tone_amp  = real'($urandom_range(8388607, 1000));
	endtask

	// half the time a steady tone per channel, otherwise noise, extremes and tiny values
	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input logic ch);
		case ($urandom_range(9))
			0, 1, 2: begin
				return SAMPLE_BITS'($urandom);
			end
			3: begin
				case ($urandom_range(3))
					0:       return S_MAX;
					1:       return S_MIN;
					2:       return '0;
					default: return '1;
				endcase
			end
			4: begin
				return SAMPLE_BITS'(int'($urandom_range(511)) - 256);
			end
			default: begin
				tone_phase[ch] += tone_step;
				return SAMPLE_BITS'($rtoi(tone_amp * $sin(tone_phase[ch])));
			end
		endcase
	endfunction

	// interleaved stereo most of the time, now and then a random channel
	task automatic random_phase(input int count, input int pause_at);
		logic ch;
		new_tone();
		for (int n = 0; n < count; n++) begin
			// sender waits here for the block to empty completely
			if (n == pause_at) begin
				drain();
			end
			ch = ($urandom_range(9) < 8) ? ~last_ch : 1'($urandom_range(1));
			send_sample(ch, pick_sample(ch));
		end
	endtask

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------

	initial begin : stimulus
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		sample_if.valid   = 1'b0;
		sample_if.channel = 1'b0;
		sample_if.sample  = '0;
		samples_sent      = 0;
		settings_used     = 0;
		sender_gaps       = 1'b1;
		last_ch           = 1'b1;
		foreach (tone_phase[i]) begin
			tone_phase[i] = 0.0;
		end
		tone_step = 0.0;
		tone_amp  = 0.0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers still at reset: both bands must come out as zero
		send_sample(1'b0, S_MAX);
		send_sample(1'b1, S_MIN);
		send_sample(1'b0, 24'h555555);
		send_sample(1'b1, 24'haaaaaa);

		// a realistic crossover: full-scale steps on each channel, lsb values
		configure(butterworth(300.0));
		send_sample(1'b0, S_MAX);
		send_sample(1'b1, S_MIN);
		send_sample(1'b0, S_MAX);
		send_sample(1'b1, S_MIN);
		send_sample(1'b0, S_MAX);
		send_sample(1'b1, S_MIN);
		send_sample(1'b0, '0);
		send_sample(1'b1, '1);
		send_sample(1'b0, 24'sd1);
		send_sample(1'b1, '0);
		send_sample(1'b0, S_MIN);
		send_sample(1'b1, S_MAX);

		// extreme coefficients: output and state saturation on both signs
		configure('{low_pass_gain: 32'h7fff_ffff, high_pass_gain: 32'h8000_0000,
			feedback_first: 32'h7fff_ffff, feedback_second: 32'h8000_0000});
		send_sample(1'b0, S_MAX);
		send_sample(1'b1, S_MIN);
		send_sample(1'b0, S_MAX);
		send_sample(1'b1, S_MIN);
		send_sample(1'b0, S_MIN);
		send_sample(1'b1, S_MAX);
		send_sample(1'b0, S_MIN);
		send_sample(1'b1, S_MAX);

		// random part
		configure(butterworth(40.0));
		random_phase(120, -1);

		// long stretch without sender idle, the receiver hold-off lands here
		configure(butterworth(1500.0));
		sender_gaps = 1'b0;
		random_phase(120, -1);
		sender_gaps = 1'b1;

		configure(butterworth(real'($urandom_range(1500, 40))));
		random_phase(120, 60);

		// arbitrary register values, mostly unstable filters
		configure('{low_pass_gain: $urandom, high_pass_gain: $urandom,
			feedback_first: $urandom, feedback_second: $urandom});
		random_phase(100, -1);

		configure('{low_pass_gain: 32'h8000_0000, high_pass_gain: 32'h7fff_ffff,
			feedback_first: 32'h8000_0000, feedback_second: 32'h7fff_ffff});
		random_phase(80, -1);

		configure(butterworth(real'($urandom_range(1500, 40))));
		random_phase(160, -1);

		drain();
		// leave room for anything stray
		repeat (40) @(posedge clk);

		$display("covered %0d samples on both channels under %0d coefficient sets, %0d band items",
			samples_sent, settings_used, bands_checked);
		$display("checked, incl. saturation extremes, a long output stall and idle pauses");
		if (bands_pending != 0) begin
			$display("%0d band items never arrived", bands_pending);
		end
		if (band_errors == 0 && bands_pending == 0) begin
			$display("** lr4_crossover_band_split: PASSED **");
		end else begin
			$display("** lr4_crossover_band_split: FAILED **");
		end
		$finish;
	end

	// ------------------------------------------------------------------
	// receiver: random stalls, one long hold-off, one window with none
	// ------------------------------------------------------------------

	initial begin : receiver
		int hold;
		bit held;
		band_if.ready = 1'b0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && bands_checked >= 200) begin
				// sender keeps offering, so the block fills and stalls its input
				held = 1'b1;
				band_if.ready <= 1'b0;
				for (hold = 0; hold < HOLD_CYCLES; hold++) begin
					@(posedge clk);
				end
			end else if (bands_checked >= 350 && bands_checked < 450) begin
				band_if.ready <= 1'b1;
			end else begin
				band_if.ready <= ($urandom_range(99) >= 15);
			end
		end
	end

	// ------------------------------------------------------------------
	// watchdog: cycles in which nothing moves on any port
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (!arst_n || (sample_if.valid && sample_if.ready) ||
			(band_if.valid && band_if.ready) || psel) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: nothing accepted for %0d cycles, %0d band items outstanding",
				$time, STALL_LIMIT, bands_pending);
			$display("** lr4_crossover_band_split: FAILED **");
			$finish;
		end
	end

endmodule

### sim.f
hw/rtl/lr4_pkg.sv
hw/rtl/lr4_if.sv
hw/rtl/lr4_ctrl.sv
hw/rtl/lr4_dp.sv
hw/rtl/lr4_crossover_band_split.sv
verif/lr4_band_checker.sv
verif/tb_top.sv
